// File: rtl/brflr_pkg.sv
// Shared types and constants of the byte ring FIFO with line reader.
package brflr_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CHUNK = 2'd1,
    OP_READ  = 2'd2,
    OP_LINE  = 2'd3
  } op_t;

  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned OCC_W  = 7;

  typedef struct packed {
    logic do_write;
    logic wr_chunk;
    logic do_refuse;
    logic rd_issue;
    logic rd_emit;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic empty;
    logic nl_held;
    logic at_nl;
  } sts_t;

endpackage

// File: rtl/brflr_ctrl.sv
// Controller state machine that sequences writes, byte reads and line reads.
module brflr_ctrl
  import brflr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  op_t  opcode,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOAD = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   line_r, line_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE) && sts.out_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    line_nxt  = line_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_WRITE, OP_CHUNK: begin
              cmd.do_write = 1'b1;
              cmd.wr_chunk = (opcode == OP_CHUNK);
            end
            OP_READ: begin
              if (sts.empty) begin
                cmd.do_refuse = 1'b1;
              end else begin
                cmd.rd_issue = 1'b1;
                line_nxt     = 1'b0;
                state_nxt    = ST_LOAD;
              end
            end
            OP_LINE: begin
              if (!sts.nl_held) begin
                cmd.do_refuse = 1'b1;
              end else begin
                cmd.rd_issue = 1'b1;
                line_nxt     = 1'b1;
                state_nxt    = ST_LOAD;
              end
            end
            default: cmd.do_refuse = 1'b1;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.emit_last = !line_r || sts.at_nl;
        if (sts.out_free) begin
          cmd.rd_emit  = 1'b1;
          cmd.rd_issue = !cmd.emit_last;
          if (cmd.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      line_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

// File: rtl/brflr_dp.sv
// Datapath: byte store, pointers, fill count, newline tracker and result register.
module brflr_dp
  import brflr_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [DATA_W-1:0] in_data,
  input  logic              in_first,
  input  logic [SIZE_W-1:0] in_size,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt, nl_ptr_r, nl_ptr_nxt;
  logic [PTR_W-1:0] wp_inc, rp_inc, rd_addr;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             nl_valid_r, nl_valid_nxt;
  logic             refused_r, refused_nxt;
  logic             full, too_big, refused_eff, push, pop;

  logic              out_valid_r, out_valid_nxt;
  logic              ok_r, ok_nxt, last_r, last_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic              load;

  assign wp_inc = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;

  assign full        = (fill_r == CNT_W'(DEPTH));
  assign too_big     = ({1'b0, 7'(fill_r)} + {1'b0, in_size}) > 8'(DEPTH);
  assign refused_eff = in_first ? too_big : refused_r;
  assign push        = cmd.do_write && !full && !(cmd.wr_chunk && refused_eff);
  assign pop         = cmd.rd_emit;
  assign rd_addr     = cmd.rd_emit ? rp_inc : rp_r;

  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.empty    = (fill_r == '0);
  assign sts.nl_held  = nl_valid_r;
  assign sts.at_nl    = nl_valid_r && (rp_r == nl_ptr_r);

  always_comb begin
    wp_nxt       = push ? wp_inc : wp_r;
    rp_nxt       = pop ? rp_inc : rp_r;
    fill_nxt     = fill_r;
    if (push) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop) begin
      fill_nxt = fill_r - 1'b1;
    end
    refused_nxt  = (cmd.do_write && cmd.wr_chunk && in_first) ? too_big : refused_r;
    nl_ptr_nxt   = nl_ptr_r;
    nl_valid_nxt = nl_valid_r;
    if (push && (in_data == NEWLINE)) begin
      nl_ptr_nxt   = wp_r;
      nl_valid_nxt = 1'b1;
    end else if (pop && sts.at_nl) begin
      nl_valid_nxt = 1'b0;
    end
  end

  assign load = cmd.do_write || cmd.do_refuse || cmd.rd_emit;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    ok_nxt        = ok_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    occ_nxt       = occ_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = cmd.do_write ? push : cmd.rd_emit;
      data_nxt      = cmd.rd_emit ? rd_data_r : '0;
      last_nxt      = cmd.rd_emit ? cmd.emit_last : 1'b1;
      occ_nxt       = fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= in_data;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      fill_r      <= '0;
      refused_r   <= 1'b0;
      nl_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      fill_r      <= fill_nxt;
      refused_r   <= refused_nxt;
      nl_valid_r  <= nl_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nl_ptr_r <= nl_ptr_nxt;
    ok_r     <= ok_nxt;
    data_r   <= data_nxt;
    last_r   <= last_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = ok_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {7'd0,
                       (occ_r == '0),
                       (occ_r == CNT_W'(DEPTH)),
                       OCC_W'(occ_r),
                       data_r};

endmodule

// File: rtl/byte_ring_fifo_line_reader_core.sv
// Top level of the byte ring FIFO with line reader.
//
//   channel | ports        | carries
//   --------+--------------+----------------------------------------------
//   input   | in_t*        | opcode, data byte, chunk first mark and size
//   result  | out_t*       | ok, data byte, last, occupancy, full, empty
//
// Byte and chunk writes and refusals load their result register directly, with no store read.
// A byte read reads the byte store into a read register, then loads the result when its slot frees.
// A line read emits each byte through the store's single read port, up to the held newline.
// The last newline held is tracked on write, so no scan precedes a line read.
// Synchronous reset clears ring pointers, fill count, state and flags, not the store or result.
// A stalled result holds the next read in place; input is taken only when the result slot frees.
module byte_ring_fifo_line_reader_core
  import brflr_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // data_in[7:0], chunk_size[14:8], zero[15]
  input  logic [2:0]  in_tuser,   // opcode[1:0], chunk_first[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // data_out[7:0], occupancy[14:8], full_res[15],
                                  // empty_res[16], zero[23:17]
  output logic        out_tuser,  // ok[0]
  output logic        out_tlast
);

  cmd_t cmd;
  sts_t sts;

  brflr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .opcode    (op_t'(in_tuser[1:0])),
    .sts       (sts),
    .cmd       (cmd)
  );

  brflr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (in_tdata[7:0]),
    .in_first   (in_tuser[2]),
    .in_size    (in_tdata[14:8]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
